/* src/smag_pkg.sv */
// ============================================================================
// smag_pkg
// Shared widths, types, register map and pipeline stage indexes for the
// Smagorinsky eddy viscosity block.
// ============================================================================
package smag_pkg;

    // Field widths of the streaming words and the register.
    localparam int STRAIN_W = 24;
    localparam int LEN_W    = 24;
    localparam int COEF_W   = 16;
    localparam int VISC_W   = 32;
    localparam int FRAC_W   = 16;

    // Internal widths, sized by the largest value that each can hold.
    localparam int ABS_W   = STRAIN_W;          // |component|, up to 2^23
    localparam int PAIR_W  = STRAIN_W + 1;      // sum of two face shears
    localparam int SQ_W    = 2 * STRAIN_W - 1;  // component squared, up to 2^46
    localparam int PSQ_W   = 2 * PAIR_W - 1;    // face sum squared, up to 2^48
    localparam int T_W     = 51;                // 2*S2 in units of 2^-32
    localparam int ROOT_W  = 26;                // floor(sqrt(T))
    localparam int RAD_W   = 2 * ROOT_W;        // radicand padded to even width
    localparam int REM_W   = ROOT_W + 2;        // partial remainder
    localparam int CL_W    = COEF_W + LEN_W;    // C0 * delta
    localparam int L_W     = 24;                // C0 * delta in Q8.16
    localparam int LL_W    = 2 * L_W;           // L squared
    localparam int Q_W     = 32;                // (C0 * delta)^2 in Q16.16
    localparam int RQ_W    = ROOT_W + Q_W;      // R * Q
    localparam int V_W     = RQ_W - FRAC_W;     // unsaturated result

    // Rounding constant, one half in Q16.
    localparam int HALF_Q16 = 32768;

    // Payload types.
    typedef logic signed [STRAIN_W-1:0] strain_t;
    typedef logic        [LEN_W-1:0]    length_t;
    typedef logic        [COEF_W-1:0]   coef_t;
    typedef logic        [VISC_W-1:0]   visc_t;

    // Register port.
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    typedef enum logic [PADDR_W-1:0] {
        REG_COEFF_C0 = 2'd0
    } reg_addr_t;

    localparam coef_t COEF_RESET = 16'd10486;

    // Pipeline stage indexes.
    localparam int SQ_STEPS = ROOT_W;
    localparam int ST_ABS   = 0;
    localparam int ST_SQR   = 1;
    localparam int ST_SUM   = 2;
    localparam int ST_ROOT0 = 3;
    localparam int ST_MUL   = ST_ROOT0 + SQ_STEPS;
    localparam int ST_OUT   = ST_MUL + 1;
    localparam int NSTAGE   = ST_OUT + 1;

endpackage

/* src/smag_in_if.sv */
// ============================================================================
// smag_in_if
// Cell word channel: strain components, mixing length and wall flag.
// ============================================================================
interface smag_in_if;
    import smag_pkg::*;

    logic    valid;
    logic    ready;
    strain_t strain_xx;
    strain_t strain_yy;
    strain_t strain_zz;
    strain_t strain_xy;
    strain_t strain_xz_lower;
    strain_t strain_xz_upper;
    strain_t strain_yz_lower;
    strain_t strain_yz_upper;
    length_t mixing_length;
    logic    at_wall;

    modport source
    (
        output valid, strain_xx, strain_yy, strain_zz, strain_xy,
               strain_xz_lower, strain_xz_upper, strain_yz_lower, strain_yz_upper,
               mixing_length, at_wall,
        input  ready
    );

    modport sink
    (
        input  valid, strain_xx, strain_yy, strain_zz, strain_xy,
               strain_xz_lower, strain_xz_upper, strain_yz_lower, strain_yz_upper,
               mixing_length, at_wall,
        output ready
    );

endinterface

/* src/smag_out_if.sv */
// ============================================================================
// smag_out_if
// Result word channel: eddy viscosity and saturation flag.
// ============================================================================
interface smag_out_if;
    import smag_pkg::*;

    logic  valid;
    logic  ready;
    visc_t eddy_viscosity;
    logic  saturated;

    modport source
    (
        output valid, eddy_viscosity, saturated,
        input  ready
    );

    modport sink
    (
        input  valid, eddy_viscosity, saturated,
        output ready
    );

endinterface

/* src/smagorinsky_eddy_viscosity.sv */
// ============================================================================
// smagorinsky_eddy_viscosity
// Streaming Smagorinsky subgrid viscosity per grid cell in fixed point:
// sqrt(2*S2) * (C0*delta)^2, zero at walls, saturated to Q16.16.
// ============================================================================
//
//  Channel    Dir   Handshake             Contents
//  cell_in    in    valid/ready           eight strains, mixing length, wall
//  visc_out   out   valid/ready           eddy viscosity, saturated flag
//  APB        in    psel/penable/pready   coefficient_c0 at byte address 0
//
//  One word enters per cycle unless the pipeline is full and the result is
//  not taken. The square root resolves one result bit per stage over 26
//  stages; there are also three front stages and two back stages.
//  Reset (rst_n low) empties the pipeline and loads C0 with 10486.
//  Each stage moves forward when any stage at or after it is empty or the
//  result is taken, so bubbles close up and a stall loses nothing.
//
module smagorinsky_eddy_viscosity
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [smag_pkg::PADDR_W-1:0] paddr,
    input  logic [smag_pkg::PDATA_W-1:0] pwdata,
    output logic [smag_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    smag_in_if.sink                     cell_in,
    smag_out_if.source                  visc_out
);
    import smag_pkg::*;

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    coef_t               c0_reg;
    logic                cfg_write;

    logic [NSTAGE-1:0]   vld_reg;
    logic [NSTAGE-1:0]   vld_next;
    logic [NSTAGE-1:0]   stg_rdy;

    // Stage ABS
    logic signed [PAIR_W-1:0] xz_sum;
    logic signed [PAIR_W-1:0] yz_sum;
    logic [ABS_W-1:0]    abs_xx_next, abs_yy_next, abs_zz_next, abs_xy_next;
    logic [PAIR_W-1:0]   abs_xz_next, abs_yz_next;
    logic [ABS_W-1:0]    abs_xx_reg, abs_yy_reg, abs_zz_reg, abs_xy_reg;
    logic [PAIR_W-1:0]   abs_xz_reg, abs_yz_reg;
    logic [CL_W-1:0]     cl_reg;
    logic                abs_wall_reg;

    // Stage SQR
    logic [CL_W-1:0]     cl_rnd;
    logic [L_W-1:0]      len_l;
    logic [SQ_W-1:0]     sq_xx_reg, sq_yy_reg, sq_zz_reg, sq_xy_reg;
    logic [PSQ_W-1:0]    sq_xz_reg, sq_yz_reg;
    logic [LL_W-1:0]     ll_reg;
    logic                sqr_wall_reg;

    // Stage SUM
    logic [T_W-1:0]      t_next;
    logic [LL_W-1:0]     ll_rnd;
    logic [T_W-1:0]      t_reg;
    logic [Q_W-1:0]      sum_q_reg;
    logic                sum_wall_reg;

    // Square root stages
    logic [RAD_W-1:0]    rt_x_reg    [SQ_STEPS];
    logic [REM_W-1:0]    rt_rem_reg  [SQ_STEPS];
    logic [ROOT_W-1:0]   rt_root_reg [SQ_STEPS];
    logic [Q_W-1:0]      rt_q_reg    [SQ_STEPS];
    logic                rt_wall_reg [SQ_STEPS];

    // Stage MUL
    logic [RQ_W-1:0]     rq_reg;
    logic                mul_wall_reg;

    // Stage OUT
    logic [RQ_W-1:0]     rq_rnd;
    logic [V_W-1:0]      v_full;
    logic                v_over;
    visc_t               visc_next;
    logic                sat_next;
    visc_t               visc_reg;
    logic                sat_reg;

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_COEFF_C0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c0_reg <= COEF_RESET;
        end
        else if (cfg_write)
        begin
            c0_reg <= pwdata[COEF_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_COEFF_C0)
        begin
            prdata = PDATA_W'(c0_reg);
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage moves when it or any later stage is
    // empty or the result word is taken.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < NSTAGE; k++)
    begin : g_rdy
        assign stg_rdy[k] = visc_out.ready || !(&vld_reg[NSTAGE-1:k]);
    end

    assign vld_next      = {vld_reg[NSTAGE-2:0], cell_in.valid};
    assign cell_in.ready = stg_rdy[ST_ABS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTAGE; k++)
            begin
                if (stg_rdy[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage ABS: face sums, magnitudes and C0 * delta.
    // ------------------------------------------------------------------
    always_comb
    begin
        xz_sum = {cell_in.strain_xz_lower[STRAIN_W-1], cell_in.strain_xz_lower}
               + {cell_in.strain_xz_upper[STRAIN_W-1], cell_in.strain_xz_upper};
        yz_sum = {cell_in.strain_yz_lower[STRAIN_W-1], cell_in.strain_yz_lower}
               + {cell_in.strain_yz_upper[STRAIN_W-1], cell_in.strain_yz_upper};
        abs_xx_next = cell_in.strain_xx[STRAIN_W-1] ? ABS_W'(-cell_in.strain_xx)
                                                    : ABS_W'(cell_in.strain_xx);
        abs_yy_next = cell_in.strain_yy[STRAIN_W-1] ? ABS_W'(-cell_in.strain_yy)
                                                    : ABS_W'(cell_in.strain_yy);
        abs_zz_next = cell_in.strain_zz[STRAIN_W-1] ? ABS_W'(-cell_in.strain_zz)
                                                    : ABS_W'(cell_in.strain_zz);
        abs_xy_next = cell_in.strain_xy[STRAIN_W-1] ? ABS_W'(-cell_in.strain_xy)
                                                    : ABS_W'(cell_in.strain_xy);
        abs_xz_next = xz_sum[PAIR_W-1] ? PAIR_W'(-xz_sum) : PAIR_W'(xz_sum);
        abs_yz_next = yz_sum[PAIR_W-1] ? PAIR_W'(-yz_sum) : PAIR_W'(yz_sum);
    end

    always_ff @(posedge clk)
    begin
        if (stg_rdy[ST_ABS])
        begin
            abs_xx_reg   <= abs_xx_next;
            abs_yy_reg   <= abs_yy_next;
            abs_zz_reg   <= abs_zz_next;
            abs_xy_reg   <= abs_xy_next;
            abs_xz_reg   <= abs_xz_next;
            abs_yz_reg   <= abs_yz_next;
            cl_reg       <= CL_W'(c0_reg) * CL_W'(cell_in.mixing_length);
            abs_wall_reg <= cell_in.at_wall;
        end
    end

    // ------------------------------------------------------------------
    // Stage SQR: squares of the components and of the rounded length.
    // ------------------------------------------------------------------
    always_comb
    begin
        cl_rnd = cl_reg + CL_W'(HALF_Q16);
        len_l  = cl_rnd[CL_W-1:FRAC_W];
    end

    always_ff @(posedge clk)
    begin
        if (stg_rdy[ST_SQR])
        begin
            sq_xx_reg    <= SQ_W'((2 * ABS_W)'(abs_xx_reg) * (2 * ABS_W)'(abs_xx_reg));
            sq_yy_reg    <= SQ_W'((2 * ABS_W)'(abs_yy_reg) * (2 * ABS_W)'(abs_yy_reg));
            sq_zz_reg    <= SQ_W'((2 * ABS_W)'(abs_zz_reg) * (2 * ABS_W)'(abs_zz_reg));
            sq_xy_reg    <= SQ_W'((2 * ABS_W)'(abs_xy_reg) * (2 * ABS_W)'(abs_xy_reg));
            sq_xz_reg    <= PSQ_W'((2 * PAIR_W)'(abs_xz_reg) * (2 * PAIR_W)'(abs_xz_reg));
            sq_yz_reg    <= PSQ_W'((2 * PAIR_W)'(abs_yz_reg) * (2 * PAIR_W)'(abs_yz_reg));
            ll_reg       <= LL_W'(len_l) * LL_W'(len_l);
            sqr_wall_reg <= abs_wall_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage SUM: T = 2*S2 exactly, and the rounded Q16.16 length square.
    // ------------------------------------------------------------------
    always_comb
    begin
        t_next = ((T_W'(sq_xx_reg) + T_W'(sq_yy_reg) + T_W'(sq_zz_reg)) << 1)
               + (T_W'(sq_xy_reg) << 2)
               + T_W'(sq_xz_reg) + T_W'(sq_yz_reg);
        ll_rnd = ll_reg + LL_W'(HALF_Q16);
    end

    always_ff @(posedge clk)
    begin
        if (stg_rdy[ST_SUM])
        begin
            t_reg        <= t_next;
            sum_q_reg    <= ll_rnd[LL_W-1:FRAC_W];
            sum_wall_reg <= sqr_wall_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root: one restoring step per stage, two radicand bits each.
    // ------------------------------------------------------------------
    for (genvar j = 0; j < SQ_STEPS; j++)
    begin : g_root
        logic [RAD_W-1:0]  x_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [Q_W-1:0]    q_in;
        logic              wall_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              take;

        if (j == 0)
        begin : g_first
            assign x_in    = RAD_W'(t_reg);
            assign rem_in  = '0;
            assign root_in = '0;
            assign q_in    = sum_q_reg;
            assign wall_in = sum_wall_reg;
        end
        else
        begin : g_next
            assign x_in    = rt_x_reg[j-1];
            assign rem_in  = rt_rem_reg[j-1];
            assign root_in = rt_root_reg[j-1];
            assign q_in    = rt_q_reg[j-1];
            assign wall_in = rt_wall_reg[j-1];
        end

        // Bring down the next radicand pair and try root*4 + 1.
        always_comb
        begin
            rem_sh = {rem_in[REM_W-3:0], x_in[RAD_W-1 -: 2]};
            trial  = {root_in, 2'b01};
            take   = (rem_sh >= trial);
        end

        always_ff @(posedge clk)
        begin
            if (stg_rdy[ST_ROOT0 + j])
            begin
                rt_x_reg[j]    <= {x_in[RAD_W-3:0], 2'b00};
                rt_rem_reg[j]  <= take ? (rem_sh - trial) : rem_sh;
                rt_root_reg[j] <= {root_in[ROOT_W-2:0], take};
                rt_q_reg[j]    <= q_in;
                rt_wall_reg[j] <= wall_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage MUL: R * Q.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (stg_rdy[ST_MUL])
        begin
            rq_reg       <= RQ_W'(rt_root_reg[SQ_STEPS-1]) * RQ_W'(rt_q_reg[SQ_STEPS-1]);
            mul_wall_reg <= rt_wall_reg[SQ_STEPS-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage OUT: round, saturate and force zero at walls.
    // ------------------------------------------------------------------
    always_comb
    begin
        rq_rnd = rq_reg + RQ_W'(HALF_Q16);
        v_full = rq_rnd[RQ_W-1:FRAC_W];
        v_over = |v_full[V_W-1:VISC_W];
        if (mul_wall_reg)
        begin
            visc_next = '0;
            sat_next  = 1'b0;
        end
        else if (v_over)
        begin
            visc_next = '1;
            sat_next  = 1'b1;
        end
        else
        begin
            visc_next = v_full[VISC_W-1:0];
            sat_next  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_rdy[ST_OUT])
        begin
            visc_reg <= visc_next;
            sat_reg  <= sat_next;
        end
    end

    assign visc_out.valid          = vld_reg[ST_OUT];
    assign visc_out.eddy_viscosity = visc_reg;
    assign visc_out.saturated      = sat_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The final square root remainder never exceeds twice the root.
    a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_MUL - 1] |->
            (rt_rem_reg[SQ_STEPS-1] <= {rt_root_reg[SQ_STEPS-1], 1'b0}))
        else $error("square root remainder out of range");

    // An accepted word occupies the first stage in the next cycle.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_in.valid && cell_in.ready) |=> vld_reg[ST_ABS])
        else $error("accepted word lost at pipeline entry");

    // The coefficient changes only through a register write.
    a_c0_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_write |=> $stable(c0_reg))
        else $error("coefficient changed without a write");

    // A saturated result carries the maximum value.
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        (visc_out.valid && visc_out.saturated) |-> (visc_out.eddy_viscosity == '1))
        else $error("saturated result is not at maximum");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for smagorinsky_eddy_viscosity. Cell words go in through
// a valid/ready channel under several coefficient settings and idle patterns.
// Each accepted word is run through an independent fixed-point predictor.
// Every result word is compared field by field with the oldest prediction.
// ============================================================================
module tb_top;
    import smag_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 9;
    localparam int PIPE_LATENCY = 31;
    localparam int CYCLE_LIMIT  = 400000;

    localparam strain_t STRAIN_MAX = 24'sh7FFFFF;
    localparam strain_t STRAIN_MIN = 24'sh800000;
    localparam strain_t STRAIN_ONE = 24'sh010000;

    typedef struct {
        strain_t xx;
        strain_t yy;
        strain_t zz;
        strain_t xy;
        strain_t xz_lo;
        strain_t xz_hi;
        strain_t yz_lo;
        strain_t yz_hi;
        length_t len;
        logic    wall;
    } cell_t;

    typedef struct {
        visc_t visc;
        logic  sat;
    } visc_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    smag_in_if  cell_if ();
    smag_out_if visc_if ();

    // Predictor state: the coefficient as the block should hold it.
    coef_t        c0_model;
    visc_result_t visc_pending[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int cycle_count    = 0;

    smagorinsky_eddy_viscosity DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cell_in  (cell_if),
        .visc_out (visc_if)
    );

    always #CLK_HALF clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: ready drops at random with the current stall rate.
    always @(negedge clk)
    begin
        visc_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare every accepted result word with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        visc_result_t want;
        if (rst_n && visc_if.valid && visc_if.ready)
        begin
            if (visc_pending.size() == 0)
            begin
                $error("unexpected result word: eddy_viscosity %0d, saturated %0b",
                       visc_if.eddy_viscosity, visc_if.saturated);
                fail_count++;
            end
            else
            begin
                want = visc_pending.pop_front();
                if (visc_if.eddy_viscosity !== want.visc)
                begin
                    $error("eddy_viscosity: expected %0d, actual %0d",
                           want.visc, visc_if.eddy_viscosity);
                    fail_count++;
                end
                if (visc_if.saturated !== want.sat)
                begin
                    $error("saturated: expected %0b, actual %0b",
                           want.sat, visc_if.saturated);
                    fail_count++;
                end
            end
        end
    end

    // Integer square root, one result bit per trial from the top down.
    function automatic longint unsigned floor_sqrt(longint unsigned radicand);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand)
                root = trial;
        end
        return root;
    endfunction

    // Eddy viscosity of one cell: sqrt(2*S2) * (C0*delta)^2 in Q16.16.
    function automatic visc_result_t predict_viscosity(cell_t c, coef_t c0);
        visc_result_t    res;
        longint          xx;
        longint          yy;
        longint          zz;
        longint          xy;
        longint          xz_sum;
        longint          yz_sum;
        longint unsigned strain_sq;
        longint unsigned root;
        longint unsigned scaled_len;
        longint unsigned len_sq;
        longint unsigned visc_wide;
        res.visc = '0;
        res.sat  = 1'b0;
        if (c.wall)
            return res;
        xx = c.xx;
        yy = c.yy;
        zz = c.zz;
        xy = c.xy;
        xz_sum = longint'(c.xz_lo) + longint'(c.xz_hi);
        yz_sum = longint'(c.yz_lo) + longint'(c.yz_hi);
        // Face averages folded in exactly: (a+b)^2 equals 4*((a+b)/2)^2.
        strain_sq = 2 * (xx * xx + yy * yy + zz * zz) + 4 * (xy * xy)
                  + xz_sum * xz_sum + yz_sum * yz_sum;
        root = floor_sqrt(strain_sq);
        scaled_len = c0;
        scaled_len = (scaled_len * c.len + HALF_Q16) >> FRAC_W;
        len_sq     = (scaled_len * scaled_len + HALF_Q16) >> FRAC_W;
        visc_wide  = (root * len_sq + HALF_Q16) >> FRAC_W;
        if (visc_wide > 64'hFFFF_FFFF)
        begin
            res.visc = '1;
            res.sat  = 1'b1;
        end
        else
        begin
            res.visc = visc_wide[VISC_W-1:0];
        end
        return res;
    endfunction

    function automatic cell_t make_uniform_cell(strain_t s, length_t len, logic wall);
        cell_t c;
        c.xx    = s;
        c.yy    = s;
        c.zz    = s;
        c.xy    = s;
        c.xz_lo = s;
        c.xz_hi = s;
        c.yz_lo = s;
        c.yz_hi = s;
        c.len   = len;
        c.wall  = wall;
        return c;
    endfunction

    // Strain of random magnitude, with the extremes and full-width values mixed in.
    function automatic strain_t random_strain();
        logic [STRAIN_W-1:0] raw;
        strain_t             s;
        int                  width;
        raw = STRAIN_W'($urandom);
        case ($urandom_range(9))
            0:       s = STRAIN_MAX;
            1:       s = STRAIN_MIN;
            2, 3:    s = strain_t'(raw);
            default:
            begin
                width = $urandom_range(1, STRAIN_W - 1);
                raw   = raw >> (STRAIN_W - width);
                s     = $urandom_range(1) ? -strain_t'(raw) : strain_t'(raw);
            end
        endcase
        return s;
    endfunction

    function automatic cell_t random_cell();
        cell_t             c;
        logic [LEN_W-1:0]  raw;
        c.xx    = random_strain();
        c.yy    = random_strain();
        c.zz    = random_strain();
        c.xy    = random_strain();
        c.xz_lo = random_strain();
        c.xz_hi = random_strain();
        c.yz_lo = random_strain();
        c.yz_hi = random_strain();
        raw = LEN_W'($urandom);
        case ($urandom_range(9))
            0:       c.len = '1;
            1:       c.len = '0;
            2, 3:    c.len = raw;
            default: c.len = raw >> $urandom_range(1, LEN_W - 1);
        endcase
        c.wall = ($urandom_range(7) == 0);
        return c;
    endfunction

    // Send one cell word, with random idle cycles ahead of it.
    task automatic send_cell(input cell_t c);
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            cell_if.valid <= 1'b0;
            @(negedge clk);
        end
        cell_if.valid           <= 1'b1;
        cell_if.strain_xx       <= c.xx;
        cell_if.strain_yy       <= c.yy;
        cell_if.strain_zz       <= c.zz;
        cell_if.strain_xy       <= c.xy;
        cell_if.strain_xz_lower <= c.xz_lo;
        cell_if.strain_xz_upper <= c.xz_hi;
        cell_if.strain_yz_lower <= c.yz_lo;
        cell_if.strain_yz_upper <= c.yz_hi;
        cell_if.mixing_length   <= c.len;
        cell_if.at_wall         <= c.wall;
        do
            @(posedge clk);
        while (!cell_if.ready);
        visc_pending.push_back(predict_viscosity(c, c0_model));
    endtask

    // Stop sending and hold off until every predicted word has come back.
    task automatic wait_results_drained();
        @(negedge clk);
        cell_if.valid <= 1'b0;
        while (visc_pending.size() != 0)
            @(posedge clk);
    endtask

    // Read the coefficient register back and compare with the model copy.
    task automatic check_coefficient();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= REG_COEFF_C0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== PDATA_W'(c0_model))
        begin
            $error("coefficient_c0: expected %0d, actual %0d", c0_model, prdata);
            fail_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write the coefficient with junk in the unused upper bits, then read it back.
    task automatic write_coefficient(input coef_t value);
        logic [PDATA_W-COEF_W-1:0] junk;
        junk = (PDATA_W - COEF_W)'($urandom);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_COEFF_C0;
        pwdata  <= {junk, value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        c0_model = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        check_coefficient();
    endtask

    // Extremes of every field, wall cells, zero width and face cancellation.
    task automatic test_directed_extremes();
        cell_t c;
        check_coefficient();
        send_cell(make_uniform_cell('0, '1, 1'b0));
        send_cell(make_uniform_cell(STRAIN_MAX, '1, 1'b0));
        send_cell(make_uniform_cell(STRAIN_MIN, '1, 1'b0));
        send_cell(make_uniform_cell(STRAIN_MAX, '1, 1'b1));
        send_cell(make_uniform_cell(STRAIN_MIN, '1, 1'b1));
        send_cell(make_uniform_cell(STRAIN_MIN, '0, 1'b0));
        send_cell(make_uniform_cell(STRAIN_MAX, 24'd1, 1'b0));
        send_cell(make_uniform_cell(-24'sd1, '1, 1'b0));
        send_cell(make_uniform_cell(24'sd1, '1, 1'b0));
        send_cell(make_uniform_cell(STRAIN_ONE, 24'h100000, 1'b0));
        // Opposite face shears nearly cancel to the centre.
        c = make_uniform_cell('0, '1, 1'b0);
        c.xz_lo = STRAIN_MAX;
        c.xz_hi = STRAIN_MIN;
        c.yz_lo = STRAIN_MIN;
        c.yz_hi = STRAIN_MAX;
        send_cell(c);
        // One component at its most negative, the rest zero.
        for (int k = 0; k < 8; k++)
        begin
            c = make_uniform_cell('0, 24'h0A0000, 1'b0);
            case (k)
                0: c.xx    = STRAIN_MIN;
                1: c.yy    = STRAIN_MIN;
                2: c.zz    = STRAIN_MIN;
                3: c.xy    = STRAIN_MIN;
                4: c.xz_lo = STRAIN_MIN;
                5: c.xz_hi = STRAIN_MIN;
                6: c.yz_lo = STRAIN_MIN;
                default: c.yz_hi = STRAIN_MIN;
            endcase
            send_cell(c);
        end
        // Mixed signs across the components.
        c.xx    = 24'sh012345;
        c.yy    = -24'sh00ABCD;
        c.zz    = 24'sh000777;
        c.xy    = -24'sh020000;
        c.xz_lo = 24'sh003000;
        c.xz_hi = -24'sh001000;
        c.yz_lo = -24'sh004444;
        c.yz_hi = -24'sh005555;
        c.len   = 24'h0A8000;
        c.wall  = 1'b0;
        send_cell(c);
        wait_results_drained();
    endtask

    // Zero, full-scale and smallest coefficient against a few fixed cells and one random cell.
    task automatic test_coefficient_extremes();
        coef_t settings [3];
        settings[0] = '0;
        settings[1] = '1;
        settings[2] = 16'd1;
        foreach (settings[i])
        begin
            write_coefficient(settings[i]);
            send_cell(make_uniform_cell(STRAIN_MAX, '1, 1'b0));
            send_cell(make_uniform_cell(STRAIN_MIN, '1, 1'b0));
            send_cell(make_uniform_cell(STRAIN_ONE, 24'h100000, 1'b0));
            send_cell(make_uniform_cell(24'sd1, 24'd1, 1'b0));
            send_cell(make_uniform_cell(STRAIN_MAX, '1, 1'b1));
            send_cell(random_cell());
            wait_results_drained();
        end
    endtask

    // The sender pauses until the pipeline has emptied, then resumes while the receiver stalls at random.
    task automatic test_drain_pause();
        write_coefficient(COEF_RESET);
        for (int i = 0; i < 20; i++)
            send_cell(random_cell());
        wait_results_drained();
        recv_stall_pct = 49;
        for (int i = 0; i < 20; i++)
            send_cell(random_cell());
        wait_results_drained();
        recv_stall_pct = 0;
    endtask

    // Random cells under one coefficient and one idle pattern.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input coef_t c0, input int count);
        write_coefficient(c0);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            send_cell(random_cell());
        wait_results_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        rst_n                   <= 1'b0;
        psel                    <= 1'b0;
        penable                 <= 1'b0;
        pwrite                  <= 1'b0;
        paddr                   <= REG_COEFF_C0;
        pwdata                  <= '0;
        cell_if.valid           <= 1'b0;
        cell_if.strain_xx       <= '0;
        cell_if.strain_yy       <= '0;
        cell_if.strain_zz       <= '0;
        cell_if.strain_xy       <= '0;
        cell_if.strain_xz_lower <= '0;
        cell_if.strain_xz_upper <= '0;
        cell_if.strain_yz_lower <= '0;
        cell_if.strain_yz_upper <= '0;
        cell_if.mixing_length   <= '0;
        cell_if.at_wall         <= 1'b0;
        c0_model = COEF_RESET;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_extremes();
        test_coefficient_extremes();
        test_drain_pause();
        test_random_traffic(0, 0, COEF_RESET, 300);
        test_random_traffic(49, 0, '1, 300);
        test_random_traffic(0, 49, 16'd1, 300);
        test_random_traffic(14, 14, coef_t'($urandom), 300);
        test_random_traffic(0, 0, coef_t'($urandom), 300);
        test_random_traffic(14, 14, coef_t'($urandom_range(20000)), 300);

        // Let any stray word surface before the verdict.
        wait_results_drained();
        repeat (PIPE_LATENCY + 10) @(posedge clk);
        if (fail_count == 0 && visc_pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
src/smag_pkg.sv
src/smag_in_if.sv
src/smag_out_if.sv
src/smagorinsky_eddy_viscosity.sv
test/tb_top.sv
